@@ rtl/smvt_pkg.sv @@
// package: payload types, codes and sizes for the stack machine with variable table
package smvt_pkg;
    localparam int STACK_DEPTH_D = 128;
    localparam int TABLE_DEPTH_D = 128;
    localparam int KEY_BITS_D    = 16;

    typedef enum logic [2:0] {
        K_PUSH  = 3'd0,
        K_ADD   = 3'd1,
        K_SUB   = 3'd2,
        K_MUL   = 3'd3,
        K_DIV   = 3'd4,
        K_LOAD  = 3'd5,
        K_STORE = 3'd6,
        K_NOP   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNDER    = 3'd1,
        ST_OVER     = 3'd2,
        ST_DIVZ     = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] operand;
        logic [15:0]        name_key;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] top_value;
        logic [7:0]         depth;
        logic               done_res;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_SRCH,
        S_LDRD,
        S_WR,
        S_POPRD,
        S_TOPRD,
        S_OUT
    } t_state;
endpackage

@@ rtl/stack_machine_with_variable_table_top.sv @@
// top level: stack machine instruction executor with a key/value variable table
// One beat in gives one beat out. Div runs a radix-2 restoring divider of 48 steps;
// load scans the table one entry a cycle. The stack and the table sit in synchronous
// memories with one read and one write port and registered reads, and each
// instruction reads, modifies and writes them in turn; a last beat reads the popped
// result in place of the top. One item is in flight at a time; the output register
// frees the input side as soon as the result is taken.
module stack_machine_with_variable_table_top #(
    parameter int STACK_DEPTH = smvt_pkg::STACK_DEPTH_D,
    parameter int TABLE_DEPTH = smvt_pkg::TABLE_DEPTH_D,
    parameter int KEY_BITS    = smvt_pkg::KEY_BITS_D
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  smvt_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output smvt_pkg::t_out o_data
);
    import smvt_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int TCW = $clog2(TABLE_DEPTH + 1);

    logic [31:0]       r_stk [STACK_DEPTH];
    logic [KEY_BITS-1:0] r_tkey [TABLE_DEPTH];
    logic [31:0]       r_tval [TABLE_DEPTH];

    t_state r_st, n_st;
    t_in    r_in;
    logic [SCW-1:0] r_cnt, n_cnt;
    logic [TCW-1:0] r_tcnt, n_tcnt;
    logic r_halt, n_halt;
    logic [31:0] r_a, r_b, n_a, n_b;
    logic [2:0]  r_stat, n_stat;
    logic [TCW-1:0] r_idx, n_idx;
    logic r_ov, n_ov;
    t_out r_out, n_out;

    // divider and multiplier product
    logic [63:0] r_dq;
    logic [32:0] r_rem;
    logic [5:0]  r_dstep;
    logic        r_dneg;
    logic [31:0] r_dd;
    logic [63:0] r_prod;

    // memory access controls
    logic [SAW-1:0] s_raddr, s_waddr;
    logic           s_we;
    logic [31:0]    s_wdata, r_srd;
    logic [TAW-1:0] t_raddr, t_waddr;
    logic           t_we;
    logic [KEY_BITS-1:0] r_trk;
    logic [31:0]    r_trv;

    logic [KEY_BITS-1:0] key;
    assign key = KEY_BITS'(r_in.name_key);

    always_ff @(posedge i_clk) begin
        if (s_we) r_stk[s_waddr] <= s_wdata;
        r_srd <= r_stk[s_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tkey[t_waddr] <= key;
            r_tval[t_waddr] <= r_b;
        end
        r_trk <= r_tkey[t_raddr];
        r_trv <= r_tval[t_raddr];
    end

    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    logic signed [32:0] sum_add, sum_sub;
    logic [31:0] div_q32;
    logic [63:0] div_qs;
    assign sum_add = {r_a[31], r_a} + {r_b[31], r_b};
    assign sum_sub = {r_a[31], r_a} - {r_b[31], r_b};
    assign div_qs  = r_dneg ? (~r_dq + 64'd1) : r_dq;
    assign div_q32 = sat64(div_qs);

    always_ff @(posedge i_clk) begin
        r_prod <= 64'($signed(r_srd) * $signed(r_b));
        if (r_st == S_EXEC) begin
            r_dneg  <= r_srd[31] ^ r_b[31];
            r_dd    <= r_b[31] ? (~r_b + 32'd1) : r_b;
            r_dq    <= {(r_srd[31] ? (~r_srd + 32'd1) : r_srd), 32'd0};
            r_rem   <= '0;
            r_dstep <= '0;
        end else if (r_st == S_DIV) begin
            logic [32:0] sh;
            logic [32:0] df;
            sh = {r_rem[31:0], r_dq[63]};
            df = sh - {1'b0, r_dd};
            if (!df[32]) begin
                r_rem <= df;
                r_dq  <= {r_dq[62:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_dq  <= {r_dq[62:0], 1'b0};
            end
            r_dstep <= r_dstep + 6'd1;
        end
    end

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:   if (i_valid && o_ready) n_st = S_RD;
            S_RD:     n_st = S_EXEC;
            S_EXEC: begin
                if (r_halt || r_stat != ST_OK) n_st = S_WR;
                else begin
                    unique case (t_kind'(r_in.kind))
                        K_MUL:   n_st = S_MUL;
                        K_DIV:   n_st = S_DIV;
                        K_LOAD:  n_st = S_SRCH;
                        default: n_st = S_WR;
                    endcase
                end
            end
            S_MUL:    n_st = S_WR;
            S_DIV:    if (r_dstep == 6'd47) n_st = S_DIVFIN;
            S_DIVFIN: n_st = S_WR;
            S_SRCH: begin
                if (r_idx > r_tcnt) n_st = S_WR;
                else if (r_trk == key) n_st = S_LDRD;
            end
            S_LDRD:   n_st = S_WR;
            S_WR:     n_st = r_in.last ? S_POPRD : S_TOPRD;
            S_POPRD:  n_st = S_OUT;
            S_TOPRD:  n_st = S_OUT;
            S_OUT:    if (!r_ov) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt = r_cnt; n_tcnt = r_tcnt; n_halt = r_halt;
        n_a = r_a; n_b = r_b; n_stat = r_stat; n_idx = r_idx;
        n_ov = r_ov; n_out = r_out;
        s_raddr = SAW'(r_cnt - SCW'(1)); s_waddr = '0; s_we = 1'b0; s_wdata = r_a;
        t_raddr = TAW'(r_idx); t_waddr = TAW'(r_tcnt); t_we = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                n_stat = ST_OK;
                n_idx  = '0;
            end
            S_RD: begin
                n_b = r_srd;
                s_raddr = SAW'(r_cnt - SCW'(2));
            end
            S_EXEC: begin
                n_b = r_b; n_a = r_srd;
                if (!r_halt) begin
                    priority case (t_kind'(r_in.kind))
                        K_PUSH: if (r_cnt >= SCW'(STACK_DEPTH)) n_stat = ST_OVER;
                        K_ADD, K_SUB, K_MUL:
                            if (r_cnt < SCW'(2)) n_stat = ST_UNDER;
                        K_DIV: begin
                            if (r_cnt < SCW'(2)) n_stat = ST_UNDER;
                            else if (r_b == 32'd0) n_stat = ST_DIVZ;
                        end
                        K_STORE: begin
                            if (r_tcnt >= TCW'(TABLE_DEPTH)) n_stat = ST_FULL;
                            else if (r_cnt == '0) n_stat = ST_UNDER;
                        end
                        default: ;
                    endcase
                end
                // n_stat not yet visible here; next-state uses r_stat, so latch now
                n_a = r_srd;
                t_raddr = '0;
                n_idx = TCW'(1);
            end
            S_SRCH: begin
                t_raddr = TAW'(r_idx);
                if (r_idx > r_tcnt) n_stat = ST_NOTFOUND;
                else if (r_trk == key) n_a = r_trv;
                else n_idx = r_idx + TCW'(1);
            end
            S_LDRD: ;
            S_MUL: begin
                n_a = sat64($signed(r_prod) >>> 16);
            end
            S_DIVFIN: n_a = div_q32;
            S_WR: begin
                if (!r_halt && r_stat == ST_OK) begin
                    unique case (t_kind'(r_in.kind))
                        K_PUSH: begin
                            s_we = 1'b1; s_waddr = SAW'(r_cnt);
                            s_wdata = r_in.operand; n_cnt = r_cnt + SCW'(1);
                        end
                        K_ADD, K_SUB, K_MUL, K_DIV: begin
                            s_we = 1'b1; s_waddr = SAW'(r_cnt - SCW'(2));
                            unique case (t_kind'(r_in.kind))
                                K_ADD:   s_wdata = sat64(64'(sum_add));
                                K_SUB:   s_wdata = sat64(64'(sum_sub));
                                default: s_wdata = r_a;
                            endcase
                            n_cnt = r_cnt - SCW'(1);
                        end
                        K_LOAD: begin
                            if (r_cnt >= SCW'(STACK_DEPTH)) n_stat = ST_OVER;
                            else begin
                                s_we = 1'b1; s_waddr = SAW'(r_cnt);
                                s_wdata = r_a; n_cnt = r_cnt + SCW'(1);
                            end
                        end
                        K_STORE: begin
                            t_we = 1'b1; n_tcnt = r_tcnt + TCW'(1);
                            n_cnt = r_cnt - SCW'(1);
                        end
                        default: ;
                    endcase
                end
            end
            S_POPRD, S_TOPRD: s_raddr = SAW'(r_cnt - SCW'(1));
            S_OUT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_out.done_res = r_in.last;
                    if (!r_in.last) begin
                        n_out.status = r_halt ? ST_OK : r_stat;
                        n_out.top_value = (r_cnt == '0) ? 32'd0 : r_srd;
                        n_out.depth = 8'(r_cnt);
                        if (r_stat != ST_OK) n_halt = 1'b1;
                    end else begin
                        if (!r_halt && r_stat != ST_OK) begin
                            n_out.status = r_stat; n_out.top_value = '0;
                            n_out.depth = 8'(r_cnt);
                        end else if (r_cnt == '0) begin
                            n_out.status = ST_UNDER; n_out.top_value = '0;
                            n_out.depth = '0;
                        end else begin
                            n_out.status = ST_OK; n_out.top_value = r_srd;
                            n_out.depth = 8'(r_cnt - SCW'(1));
                        end
                        n_cnt = '0; n_tcnt = '0; n_halt = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // state, counters, halt and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_tcnt <= '0; r_halt <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt; r_tcnt <= n_tcnt; r_halt <= n_halt; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid && o_ready) r_in <= i_data;
        r_a <= n_a; r_b <= n_b; r_stat <= n_stat; r_idx <= n_idx; r_out <= n_out;
    end
endmodule

@@ tb/stack_machine_with_variable_table_top_tb.sv @@
// testbench: random and directed instruction programs checked against a stack machine predictor
`timescale 1ns / 100ps

module stack_machine_with_variable_table_top_tb;
    import smvt_pkg::*;

    localparam int NSTK = STACK_DEPTH_D;
    localparam int NTAB = TABLE_DEPTH_D;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    stack_machine_with_variable_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] vstack [NSTK];
    logic [15:0] tkeys [NTAB];
    logic [31:0] tvals [NTAB];
    int stk_cnt = 0;
    int tab_cnt = 0;
    bit halted = 0;

    t_in pending_q[$];
    t_out expected_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_send = 0;
    bit stim_done = 0;

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_status exec_instr(t_in it);
        longint a, b, r, p;
        int i;
        case (t_kind'(it.kind))
            K_PUSH: begin
                if (stk_cnt >= NSTK) return ST_OVER;
                vstack[stk_cnt] = it.operand;
                stk_cnt++;
                return ST_OK;
            end
            K_ADD, K_SUB, K_MUL, K_DIV: begin
                if (stk_cnt < 2) return ST_UNDER;
                b = longint'($signed(vstack[stk_cnt-1]));
                a = longint'($signed(vstack[stk_cnt-2]));
                case (t_kind'(it.kind))
                    K_ADD: r = a + b;
                    K_SUB: r = a - b;
                    K_MUL: begin
                        p = a * b;
                        r = p >>> 16;
                    end
                    default: begin
                        if (b == 0) return ST_DIVZ;
                        r = (a * 65536) / b;
                    end
                endcase
                stk_cnt--;
                vstack[stk_cnt-1] = sat32(r);
                return ST_OK;
            end
            K_LOAD: begin
                for (i = 0; i < tab_cnt; i++)
                    if (tkeys[i] == it.name_key) break;
                if (i >= tab_cnt) return ST_NOTFOUND;
                if (stk_cnt >= NSTK) return ST_OVER;
                vstack[stk_cnt] = tvals[i];
                stk_cnt++;
                return ST_OK;
            end
            K_STORE: begin
                if (tab_cnt >= NTAB) return ST_FULL;
                if (stk_cnt == 0) return ST_UNDER;
                stk_cnt--;
                tkeys[tab_cnt] = it.name_key;
                tvals[tab_cnt] = vstack[stk_cnt];
                tab_cnt++;
                return ST_OK;
            end
            default: return ST_OK;
        endcase
    endfunction

    function automatic t_out predict_result(t_in it);
        t_out r;
        t_status st;
        st = ST_OK;
        if (!halted) st = exec_instr(it);
        r.done_res = it.last;
        if (!it.last) begin
            if (st != ST_OK) halted = 1;
            r.top_value = stk_cnt ? vstack[stk_cnt-1] : 32'd0;
            r.depth = stk_cnt[7:0];
        end else begin
            if (st != ST_OK) begin
                r.top_value = 0;
                r.depth = stk_cnt[7:0];
            end else if (stk_cnt == 0) begin
                st = ST_UNDER;
                r.top_value = 0;
                r.depth = 0;
            end else begin
                stk_cnt--;
                r.top_value = vstack[stk_cnt];
                r.depth = stk_cnt[7:0];
            end
            stk_cnt = 0;
            tab_cnt = 0;
            halted = 0;
        end
        r.status = st;
        return r;
    endfunction

    function automatic t_in mk(t_kind k, logic [31:0] v, logic [15:0] key, bit lst);
        t_in it;
        it.kind = k;
        it.operand = v;
        it.name_key = key;
        it.last = lst;
        return it;
    endfunction

    function automatic logic [31:0] rnd_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return $urandom_range(0, 8) << 16;
            4: return $urandom_range(0, 1) ? 32'hffff0000 : 32'h00010000;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_q.size() && !hold_send && (quiet || $urandom_range(0, 99) >= 9)) begin
                i_valid <= 1'b1;
                i_data <= pending_q[0];
                expected_q.push_back(predict_result(pending_q.pop_front()));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || $urandom_range(0, 99) >= 9;
            if (o_valid && i_ready) begin
                if (!expected_q.size()) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", o_data);
                end else begin
                    t_out e;
                    e = expected_q.pop_front();
                    if (o_data.status !== e.status || o_data.top_value !== e.top_value ||
                        o_data.depth !== e.depth || o_data.done_res !== e.done_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", e, o_data);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_program(int len);
        int n;
        int kk;
        logic [15:0] keys [4];
        for (int j = 0; j < 4; j++) keys[j] = $urandom;
        n = 0;
        for (int j = 0; j < len; j++) begin
            kk = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                pending_q.push_back(mk(t_kind'($urandom_range(0, 7)), $urandom, $urandom,
                    0));
            end else if (n < 2 || kk < 30) begin
                pending_q.push_back(mk(K_PUSH, rnd_value(), 0, 0));
                n++;
            end else if (kk < 70) begin
                pending_q.push_back(mk(t_kind'($urandom_range(1, 4)), $urandom, $urandom,
                    0));
                n--;
            end else if (kk < 85) begin
                pending_q.push_back(mk(K_STORE, $urandom, keys[$urandom_range(0, 3)], 0));
                n--;
            end else begin
                pending_q.push_back(mk(K_LOAD, $urandom, keys[$urandom_range(0, 3)], 0));
                n++;
            end
        end
        pending_q.push_back(mk(t_kind'($urandom_range(0, 7)), rnd_value(),
            keys[$urandom_range(0, 3)], 1));
    endtask

    task automatic wait_drain();
        while (pending_q.size() || expected_q.size()) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: arithmetic extremes and rounding
        pending_q.push_back(mk(K_PUSH, 32'h7fffffff, 0, 0));
        pending_q.push_back(mk(K_PUSH, 32'h7fffffff, 0, 0));
        pending_q.push_back(mk(K_ADD, 0, 0, 0));
        pending_q.push_back(mk(K_PUSH, 32'h80000000, 0, 0));
        pending_q.push_back(mk(K_MUL, 0, 0, 0));
        pending_q.push_back(mk(K_PUSH, 32'hffffffff, 0, 0));
        pending_q.push_back(mk(K_MUL, 0, 0, 0));
        pending_q.push_back(mk(K_PUSH, 32'h00000003, 0, 0));
        pending_q.push_back(mk(K_DIV, 0, 0, 0));
        pending_q.push_back(mk(K_PUSH, 32'h80000000, 0, 0));
        pending_q.push_back(mk(K_SUB, 0, 0, 0));
        pending_q.push_back(mk(K_STORE, 0, 16'hffff, 0));
        pending_q.push_back(mk(K_LOAD, 0, 16'hffff, 0));
        pending_q.push_back(mk(K_NOP, 32'hffffffff, 16'hffff, 0));
        pending_q.push_back(mk(K_PUSH, 0, 0, 0));
        pending_q.push_back(mk(K_DIV, 0, 0, 0));
        pending_q.push_back(mk(K_PUSH, 1, 0, 0));
        pending_q.push_back(mk(K_ADD, 0, 0, 1));
        pending_q.push_back(mk(K_ADD, 0, 0, 0));
        pending_q.push_back(mk(K_LOAD, 0, 16'h1234, 0));
        pending_q.push_back(mk(K_STORE, 0, 0, 1));
        pending_q.push_back(mk(K_PUSH, 32'h00018000, 0, 1));
        wait_drain();

        // stack overflow and table full
        for (int j = 0; j < NSTK + 1; j++) pending_q.push_back(mk(K_PUSH, j, 0, 0));
        pending_q.push_back(mk(K_PUSH, 0, 0, 1));
        for (int j = 0; j < NTAB + 1; j++) begin
            pending_q.push_back(mk(K_PUSH, $urandom, 0, 0));
            pending_q.push_back(mk(K_STORE, 0, j[15:0], 0));
        end
        pending_q.push_back(mk(K_LOAD, 0, 16'd5, 1));
        pending_q.push_back(mk(K_PUSH, 7, 0, 0));
        for (int j = 0; j < NSTK; j++) pending_q.push_back(mk(K_LOAD, 0, 0, 0));
        pending_q.push_back(mk(K_LOAD, 0, 0, 1));

        // hold the sender until everything is back
        hold_send = 1;
        while (expected_q.size() || i_valid) @(posedge i_clk);
        hold_send = 0;
        wait_drain();

        quiet = 1;
        repeat (60) add_program($urandom_range(1, 8));
        wait_drain();
        quiet = 0;
        while (pending_q.size() < 1080) add_program($urandom_range(1, 24));
        wait_drain();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/smvt_pkg.sv
rtl/stack_machine_with_variable_table_top.sv
tb/stack_machine_with_variable_table_top_tb.sv
